>>> design/rfpwd_pkg.sv
`default_nettype none

package rfpwd_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SHORT_MIN       = 3'd0,
    REG_SHORT_MAX       = 3'd1,
    REG_LONG_MIN        = 3'd2,
    REG_LONG_MAX        = 3'd3,
    REG_SYNC_MIN        = 3'd4,
    REG_SYNC_MAX        = 3'd5,
    REG_MIN_FRAME_BITS  = 3'd6,
    REG_SHORT_GIVES_ONE = 3'd7
  } cfg_reg_t;

  localparam int unsigned LEN_W      = 16;
  localparam int unsigned MIN_BITS_W = 6;
  localparam int unsigned FRAME_W    = 32;
  localparam int unsigned CODE_W     = 10;

  localparam logic [LEN_W-1:0] SAT_LEN = 16'hFFFF;

  localparam logic [LEN_W-1:0]      RST_SHORT_MIN       = 16'd610;
  localparam logic [LEN_W-1:0]      RST_SHORT_MAX       = 16'd810;
  localparam logic [LEN_W-1:0]      RST_LONG_MIN        = 16'd1320;
  localparam logic [LEN_W-1:0]      RST_LONG_MAX        = 16'd1520;
  localparam logic [LEN_W-1:0]      RST_SYNC_MIN        = 16'd25000;
  localparam logic [LEN_W-1:0]      RST_SYNC_MAX        = 16'd27000;
  localparam logic [MIN_BITS_W-1:0] RST_MIN_FRAME_BITS  = 6'd10;
  localparam logic                  RST_SHORT_GIVES_ONE = 1'b1;

  // 12-bit DIP remote frame: prologue bit clear, epilogue bit set
  localparam logic [MIN_BITS_W-1:0] DIP_FRAME_BITS   = 6'd12;
  localparam int unsigned           DIP_PROLOGUE_POS = 31;
  localparam int unsigned           DIP_EPILOGUE_POS = 20;
  localparam int unsigned           DIP_CODE_LSB     = 21;

endpackage

`default_nettype wire

>>> design/rf_pulse_width_frame_decoder.sv
`default_nettype none

// Pulse-width frame decoder for on-off keyed remote bursts. Each input transfer
// carries one measured pulse length; pulses pair up, a short pulse followed by
// a sync gap opens a frame, and the second pulse of each later pair adds one
// bit (MSB first). A frame closes on an invalid pair, a full word or the end of
// a burst, and is reported through the output register when it holds at least
// min_frame_bits bits. Every pulse is decoded by a single compare-and-shift
// stage feeding the output register, so a new pulse is taken on every clock
// unless stalled; the result of a closing pulse is registered in the next cycle.
// The input stalls only while the output register holds a result that is
// itself stalled. Configuration writes are always taken (cfg_ready is tied
// high) and must be issued while the block is idle.
module rf_pulse_width_frame_decoder #(
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_pulse_len,
  input  wire logic        in_end_of_burst,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_frame_word,
  output logic [5:0]       out_frame_bits,
  output logic             out_is_dip_frame,
  output logic [9:0]       out_dip_code
);

  localparam int unsigned CNT_W = $clog2(WORD_BITS + 1);
  localparam int unsigned CMP_W = (CNT_W > rfpwd_pkg::MIN_BITS_W) ?
                                  CNT_W : rfpwd_pkg::MIN_BITS_W;

  // configuration registers
  logic [15:0] short_min_r, short_max_r, long_min_r, long_max_r;
  logic [15:0] sync_min_r, sync_max_r;
  logic [5:0]  min_frame_bits_r;
  logic        short_gives_one_r;

  // decoder state
  logic                 collecting_r, collecting_nxt;
  logic                 second_half_r, second_half_nxt;
  logic                 first_was_short_r, first_was_short_nxt;
  logic [WORD_BITS-1:0] shift_word_r, shift_word_nxt;
  logic [CNT_W-1:0]     bit_count_r, bit_count_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] frame_word_r, frame_word_nxt;
  logic [5:0]  frame_bits_r, frame_bits_nxt;
  logic        is_dip_r, is_dip_nxt;
  logic [9:0]  dip_code_r, dip_code_nxt;

  logic                 in_fire;
  logic                 len_short, is_long, is_sync;
  logic                 bit_ok, bit_val, add_bit;
  logic                 close_inv, close_full, sync_start, emit, clear_word;
  logic [WORD_BITS-1:0] bit_mask, word_m;
  logic [CNT_W-1:0]     cnt_m;
  logic [CMP_W-1:0]     cnt_ext, need_ext;
  logic [5:0]           need;

  function automatic logic in_range(input logic [15:0] p, input logic [15:0] lo,
                                    input logic [15:0] hi);
    return (p != rfpwd_pkg::SAT_LEN) && (p >= lo) && (p <= hi);
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign in_fire   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_min_r       <= rfpwd_pkg::RST_SHORT_MIN;
      short_max_r       <= rfpwd_pkg::RST_SHORT_MAX;
      long_min_r        <= rfpwd_pkg::RST_LONG_MIN;
      long_max_r        <= rfpwd_pkg::RST_LONG_MAX;
      sync_min_r        <= rfpwd_pkg::RST_SYNC_MIN;
      sync_max_r        <= rfpwd_pkg::RST_SYNC_MAX;
      min_frame_bits_r  <= rfpwd_pkg::RST_MIN_FRAME_BITS;
      short_gives_one_r <= rfpwd_pkg::RST_SHORT_GIVES_ONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (rfpwd_pkg::cfg_reg_t'(cfg_index))
        rfpwd_pkg::REG_SHORT_MIN:       short_min_r       <= cfg_data;
        rfpwd_pkg::REG_SHORT_MAX:       short_max_r       <= cfg_data;
        rfpwd_pkg::REG_LONG_MIN:        long_min_r        <= cfg_data;
        rfpwd_pkg::REG_LONG_MAX:        long_max_r        <= cfg_data;
        rfpwd_pkg::REG_SYNC_MIN:        sync_min_r        <= cfg_data;
        rfpwd_pkg::REG_SYNC_MAX:        sync_max_r        <= cfg_data;
        rfpwd_pkg::REG_MIN_FRAME_BITS:  min_frame_bits_r  <= cfg_data[5:0];
        rfpwd_pkg::REG_SHORT_GIVES_ONE: short_gives_one_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len_short = in_range(in_pulse_len, short_min_r, short_max_r);
    is_long   = in_range(in_pulse_len, long_min_r, long_max_r);
    is_sync   = in_range(in_pulse_len, sync_min_r, sync_max_r);

    // short wins over long when the ranges overlap
    bit_ok  = len_short || is_long;
    bit_val = len_short ? short_gives_one_r : !short_gives_one_r;

    add_bit    = second_half_r && collecting_r && bit_ok;
    close_inv  = second_half_r && collecting_r && !bit_ok;
    sync_start = second_half_r && !collecting_r && first_was_short_r && is_sync;

    for (int i = 0; i < int'(WORD_BITS); i++) begin
      bit_mask[i] = (bit_count_r == CNT_W'(int'(WORD_BITS) - 1 - i));
    end

    // state after the bit of this pulse, before any frame close
    word_m = (add_bit && bit_val) ? (shift_word_r | bit_mask) : shift_word_r;
    cnt_m  = bit_count_r + CNT_W'(add_bit);

    close_full = add_bit && (cnt_m == CNT_W'(WORD_BITS));

    need     = (min_frame_bits_r == '0) ? 6'd1 : min_frame_bits_r;
    need_ext = CMP_W'(need);
    cnt_ext  = CMP_W'(cnt_m);
    emit     = collecting_r && (cnt_ext >= need_ext) &&
               (close_inv || close_full || in_end_of_burst);

    clear_word = close_inv || close_full || sync_start || in_end_of_burst;

    // an invalid pair is retried at once as a sync pair
    if (in_end_of_burst || close_full) begin
      collecting_nxt = 1'b0;
    end else if (close_inv) begin
      collecting_nxt = first_was_short_r && is_sync;
    end else if (sync_start) begin
      collecting_nxt = 1'b1;
    end else begin
      collecting_nxt = collecting_r;
    end

    shift_word_nxt      = clear_word ? '0 : word_m;
    bit_count_nxt       = clear_word ? '0 : cnt_m;
    second_half_nxt     = in_end_of_burst ? 1'b0 : !second_half_r;
    first_was_short_nxt = second_half_r ? first_was_short_r : len_short;
  end

  generate
    if (WORD_BITS >= rfpwd_pkg::FRAME_W) begin : g_wide
      assign frame_word_nxt = word_m[WORD_BITS-1 -: rfpwd_pkg::FRAME_W];
    end else begin : g_narrow
      assign frame_word_nxt = {word_m, (rfpwd_pkg::FRAME_W - WORD_BITS)'(0)};
    end
  endgenerate

  always_comb begin
    frame_bits_nxt = cnt_ext[5:0];
    is_dip_nxt     = (cnt_ext == CMP_W'(rfpwd_pkg::DIP_FRAME_BITS)) &&
                     !frame_word_nxt[rfpwd_pkg::DIP_PROLOGUE_POS] &&
                     frame_word_nxt[rfpwd_pkg::DIP_EPILOGUE_POS];
    dip_code_nxt   = is_dip_nxt ?
                     frame_word_nxt[rfpwd_pkg::DIP_CODE_LSB +: rfpwd_pkg::CODE_W] : '0;

    if (in_fire) begin
      out_valid_nxt = emit;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r      <= 1'b0;
      second_half_r     <= 1'b0;
      first_was_short_r <= 1'b0;
      shift_word_r      <= '0;
      bit_count_r       <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        collecting_r      <= collecting_nxt;
        second_half_r     <= second_half_nxt;
        first_was_short_r <= first_was_short_nxt;
        shift_word_r      <= shift_word_nxt;
        bit_count_r       <= bit_count_nxt;
      end
    end
  end

  // load the result only on a transfer that closes a reportable frame
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      frame_word_r <= frame_word_nxt;
      frame_bits_r <= frame_bits_nxt;
      is_dip_r     <= is_dip_nxt;
      dip_code_r   <= dip_code_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_word   = frame_word_r;
  assign out_frame_bits   = frame_bits_r;
  assign out_is_dip_frame = is_dip_r;
  assign out_dip_code     = dip_code_r;

`ifndef SYNTHESIS
  a_burst_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_end_of_burst |=> !collecting_r && !second_half_r)
    else $error("burst end did not return to hunting");

  a_count_below_word: assert property (@(posedge clk) disable iff (!rst_n)
    bit_count_r < CNT_W'(WORD_BITS))
    else $error("bit count reached word size without closing");

  a_hunting_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !collecting_r |-> (shift_word_r == '0) && (bit_count_r == '0))
    else $error("shift word not clear while hunting");

  a_dip_is_twelve: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_dip_frame |-> out_frame_bits == rfpwd_pkg::DIP_FRAME_BITS)
    else $error("dip frame flagged with wrong bit count");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && $past(in_fire && emit) || $past(out_valid))
    else $error("input stalled with no pending result");
`endif

endmodule

`default_nettype wire

>>> dv/rf_pulse_width_frame_decoder_tb.sv
`timescale 1ns / 1ps

module rf_pulse_width_frame_decoder_tb;

  typedef struct packed {
    logic [rfpwd_pkg::FRAME_W-1:0]    word;
    logic [rfpwd_pkg::MIN_BITS_W-1:0] bits;
    logic                             dip;
    logic [rfpwd_pkg::CODE_W-1:0]     code;
  } frame_t;

  typedef struct {
    logic [rfpwd_pkg::LEN_W-1:0]      short_min;
    logic [rfpwd_pkg::LEN_W-1:0]      short_max;
    logic [rfpwd_pkg::LEN_W-1:0]      long_min;
    logic [rfpwd_pkg::LEN_W-1:0]      long_max;
    logic [rfpwd_pkg::LEN_W-1:0]      sync_min;
    logic [rfpwd_pkg::LEN_W-1:0]      sync_max;
    logic [rfpwd_pkg::MIN_BITS_W-1:0] min_bits;
    logic                             short_one;
  } decode_cfg_t;

  typedef enum {END_NONE, END_BURST, END_BAD} frame_end_t;

  // Decoder prediction plus the queue of frames still owed by the block
  class frame_scoreboard;
    decode_cfg_t cfg;
    bit in_frame;
    bit odd_pulse;
    bit lead_short;
    logic [rfpwd_pkg::FRAME_W-1:0] acc_word;
    int acc_count;
    frame_t frames_due[$];
    int fail_count;

    function new();
      cfg.short_min = rfpwd_pkg::RST_SHORT_MIN;
      cfg.short_max = rfpwd_pkg::RST_SHORT_MAX;
      cfg.long_min  = rfpwd_pkg::RST_LONG_MIN;
      cfg.long_max  = rfpwd_pkg::RST_LONG_MAX;
      cfg.sync_min  = rfpwd_pkg::RST_SYNC_MIN;
      cfg.sync_max  = rfpwd_pkg::RST_SYNC_MAX;
      cfg.min_bits  = rfpwd_pkg::RST_MIN_FRAME_BITS;
      cfg.short_one = rfpwd_pkg::RST_SHORT_GIVES_ONE;
      odd_pulse = 0;
      lead_short = 0;
      fail_count = 0;
      go_hunt();
    endfunction

    function void report(string msg);
      $display("MISMATCH: %s", msg);
      fail_count++;
    endfunction

    function int pending();
      return frames_due.size();
    endfunction

    function void set_reg(rfpwd_pkg::cfg_reg_t idx, logic [15:0] v);
      case (idx)
        rfpwd_pkg::REG_SHORT_MIN:       cfg.short_min = v;
        rfpwd_pkg::REG_SHORT_MAX:       cfg.short_max = v;
        rfpwd_pkg::REG_LONG_MIN:        cfg.long_min = v;
        rfpwd_pkg::REG_LONG_MAX:        cfg.long_max = v;
        rfpwd_pkg::REG_SYNC_MIN:        cfg.sync_min = v;
        rfpwd_pkg::REG_SYNC_MAX:        cfg.sync_max = v;
        rfpwd_pkg::REG_MIN_FRAME_BITS:  cfg.min_bits = v[rfpwd_pkg::MIN_BITS_W-1:0];
        rfpwd_pkg::REG_SHORT_GIVES_ONE: cfg.short_one = v[0];
        default: ;
      endcase
    endfunction

    function bit in_band(logic [rfpwd_pkg::LEN_W-1:0] p, logic [rfpwd_pkg::LEN_W-1:0] lo,
                         logic [rfpwd_pkg::LEN_W-1:0] hi);
      return p != rfpwd_pkg::SAT_LEN && p >= lo && p <= hi;
    endfunction

    function void go_hunt();
      in_frame = 0;
      acc_word = '0;
      acc_count = 0;
    endfunction

    function bit close_frame();
      int need;
      frame_t f;
      bit made;
      made = 0;
      need = (cfg.min_bits == 0) ? 1 : int'(cfg.min_bits);
      if (in_frame && acc_count >= need) begin
        f.word = acc_word;
        f.bits = rfpwd_pkg::MIN_BITS_W'(acc_count);
        f.dip = (acc_count == int'(rfpwd_pkg::DIP_FRAME_BITS)) &&
                !acc_word[rfpwd_pkg::DIP_PROLOGUE_POS] &&
                acc_word[rfpwd_pkg::DIP_EPILOGUE_POS];
        f.code = f.dip ? acc_word[rfpwd_pkg::DIP_CODE_LSB +: rfpwd_pkg::CODE_W] : '0;
        frames_due.push_back(f);
        made = 1;
      end
      go_hunt();
      return made;
    endfunction

    function void try_sync(logic [rfpwd_pkg::LEN_W-1:0] p);
      if (lead_short && in_band(p, cfg.sync_min, cfg.sync_max)) begin
        in_frame = 1;
        acc_word = '0;
        acc_count = 0;
      end
    endfunction

    function void note_pulse(logic [rfpwd_pkg::LEN_W-1:0] p, logic eob);
      bit made;
      int b;
      made = 0;
      if (!odd_pulse) begin
        lead_short = in_band(p, cfg.short_min, cfg.short_max);
        odd_pulse = 1;
      end else begin
        odd_pulse = 0;
        if (!in_frame) begin
          try_sync(p);
        end else begin
          if (in_band(p, cfg.short_min, cfg.short_max)) b = int'(cfg.short_one);
          else if (in_band(p, cfg.long_min, cfg.long_max)) b = int'(!cfg.short_one);
          else b = -1;
          if (b < 0) begin
            made = close_frame();
            // a broken pair may itself open the next frame
            try_sync(p);
          end else begin
            if (b == 1) acc_word[rfpwd_pkg::FRAME_W-1-acc_count] = 1'b1;
            acc_count++;
            if (acc_count >= rfpwd_pkg::FRAME_W) made = close_frame();
          end
        end
      end
      if (eob) begin
        if (!made) void'(close_frame());
        else go_hunt();
        odd_pulse = 0;
      end
    endfunction

    function void check_frame(frame_t got);
      frame_t want;
      if (frames_due.size() == 0) begin
        report($sformatf("unexpected frame word %h bits %0d", got.word, got.bits));
        return;
      end
      want = frames_due.pop_front();
      if (got.word !== want.word)
        report($sformatf("frame_word got %h expected %h", got.word, want.word));
      if (got.bits !== want.bits)
        report($sformatf("frame_bits got %0d expected %0d", got.bits, want.bits));
      if (got.dip !== want.dip)
        report($sformatf("is_dip_frame got %b expected %b", got.dip, want.dip));
      if (got.code !== want.code)
        report($sformatf("dip_code got %h expected %h", got.code, want.code));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_pulse_len;
  logic        in_end_of_burst;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_frame_word;
  logic [5:0]  out_frame_bits;
  logic        out_is_dip_frame;
  logic [9:0]  out_dip_code;

  frame_scoreboard sb;
  int items_sent;
  int hold_cycles;
  bit calm;
  bit half_pending;

  rf_pulse_width_frame_decoder u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pulse_len     (in_pulse_len),
    .in_end_of_burst  (in_end_of_burst),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_word   (out_frame_word),
    .out_frame_bits   (out_frame_bits),
    .out_is_dip_frame (out_is_dip_frame),
    .out_dip_code     (out_dip_code)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400us;
    $display("Some tests failed");
    $finish;
  end

  // Watch both channels; every transfer goes through the scoreboard
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_frame({out_frame_word, out_frame_bits, out_is_dip_frame, out_dip_code});
      if (in_valid && !in_stall)
        sb.note_pulse(in_pulse_len, in_end_of_burst);
    end
  end

  // Receiver: random stalls, calm stretches, and a long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 16);
      end
    end
  end

  function automatic logic [rfpwd_pkg::LEN_W-1:0] pick(logic [rfpwd_pkg::LEN_W-1:0] lo,
                                                       logic [rfpwd_pkg::LEN_W-1:0] hi);
    logic [rfpwd_pkg::LEN_W-1:0] v;
    if (lo > hi) return lo;
    v = rfpwd_pkg::LEN_W'($urandom_range(hi, lo));
    if (v == rfpwd_pkg::SAT_LEN && lo != rfpwd_pkg::SAT_LEN) v--;
    return v;
  endfunction

  // Length that is neither short nor long; saturation always qualifies
  function automatic logic [rfpwd_pkg::LEN_W-1:0] bad_pulse();
    logic [rfpwd_pkg::LEN_W-1:0] v;
    repeat (8) begin
      v = rfpwd_pkg::LEN_W'($urandom);
      if (!sb.in_band(v, sb.cfg.short_min, sb.cfg.short_max) &&
          !sb.in_band(v, sb.cfg.long_min, sb.cfg.long_max))
        return v;
    end
    return rfpwd_pkg::SAT_LEN;
  endfunction

  task automatic send_pulse(input logic [rfpwd_pkg::LEN_W-1:0] len, input logic eob);
    if (!calm && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pulse_len <= len;
    in_end_of_burst <= eob;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    half_pending = eob ? 1'b0 : !half_pending;
  endtask

  task automatic send_frame(input int nbits, input bit dip_like, input frame_end_t ending);
    logic [31:0] pattern;
    logic [rfpwd_pkg::LEN_W-1:0] second;
    bit want;
    pattern = $urandom;
    if (dip_like) begin
      nbits = int'(rfpwd_pkg::DIP_FRAME_BITS);
      pattern[rfpwd_pkg::DIP_PROLOGUE_POS] = 1'b0;
      pattern[rfpwd_pkg::DIP_EPILOGUE_POS] = 1'b1;
    end
    // realign to a pair boundary
    if (half_pending) send_pulse(rfpwd_pkg::LEN_W'($urandom), 1'b0);
    send_pulse(pick(sb.cfg.short_min, sb.cfg.short_max), 1'b0);
    send_pulse(pick(sb.cfg.sync_min, sb.cfg.sync_max), 1'b0);
    for (int i = 0; i < nbits; i++) begin
      want = pattern[31-i];
      second = (want == sb.cfg.short_one) ? pick(sb.cfg.short_min, sb.cfg.short_max)
                                          : pick(sb.cfg.long_min, sb.cfg.long_max);
      send_pulse(rfpwd_pkg::LEN_W'($urandom), 1'b0);
      send_pulse(second, (i == nbits - 1) && ending == END_BURST);
    end
    if (ending == END_BAD) begin
      send_pulse(rfpwd_pkg::LEN_W'($urandom), 1'b0);
      send_pulse(bad_pulse(), $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic send_noise();
    logic [rfpwd_pkg::LEN_W-1:0] v;
    repeat ($urandom_range(1, 9)) begin
      case ($urandom_range(0, 3))
        0: v = pick(sb.cfg.short_min, sb.cfg.short_max);
        1: v = pick(sb.cfg.long_min, sb.cfg.long_max);
        2: v = pick(sb.cfg.sync_min, sb.cfg.sync_max);
        default: v = rfpwd_pkg::LEN_W'($urandom);
      endcase
      send_pulse(v, $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic run_random(input int quota);
    int start;
    int r;
    frame_end_t ending;
    start = items_sent;
    while (items_sent - start < quota) begin
      if ($urandom_range(0, 99) < 75) begin
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
          0: ending = END_BURST;
          1, 2: ending = END_BAD;
          default: ending = END_NONE;
        endcase
        if (r < 15) send_frame(0, 1'b1, ending);
        else if (r < 35) send_frame(rfpwd_pkg::FRAME_W, 1'b0, ending);
        else send_frame(int'($urandom_range(1, rfpwd_pkg::FRAME_W - 1)), 1'b0, ending);
      end else begin
        send_noise();
      end
    end
  endtask

  // Stop offering pulses until every owed frame is out, then let the pipe settle
  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input rfpwd_pkg::cfg_reg_t idx, input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic apply_cfg(input decode_cfg_t c);
    logic [15:0] r;
    drain();
    write_reg(rfpwd_pkg::REG_SHORT_MIN, c.short_min);
    write_reg(rfpwd_pkg::REG_SHORT_MAX, c.short_max);
    write_reg(rfpwd_pkg::REG_LONG_MIN, c.long_min);
    write_reg(rfpwd_pkg::REG_LONG_MAX, c.long_max);
    write_reg(rfpwd_pkg::REG_SYNC_MIN, c.sync_min);
    write_reg(rfpwd_pkg::REG_SYNC_MAX, c.sync_max);
    r = 16'($urandom);
    r[rfpwd_pkg::MIN_BITS_W-1:0] = c.min_bits;
    write_reg(rfpwd_pkg::REG_MIN_FRAME_BITS, r);
    r = 16'($urandom);
    r[0] = c.short_one;
    write_reg(rfpwd_pkg::REG_SHORT_GIVES_ONE, r);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic decode_cfg_t random_cfg();
    decode_cfg_t c;
    c.short_min = rfpwd_pkg::LEN_W'($urandom_range(0, 3000));
    c.short_max = c.short_min + rfpwd_pkg::LEN_W'($urandom_range(0, 600));
    c.long_min  = c.short_max + rfpwd_pkg::LEN_W'($urandom_range(1, 2000));
    c.long_max  = c.long_min + rfpwd_pkg::LEN_W'($urandom_range(0, 800));
    c.sync_min  = c.long_max + rfpwd_pkg::LEN_W'($urandom_range(1, 20000));
    c.sync_max  = c.sync_min + rfpwd_pkg::LEN_W'($urandom_range(0, 5000));
    c.min_bits  = ($urandom_range(0, 9) == 0) ? '0 :
                  rfpwd_pkg::MIN_BITS_W'($urandom_range(1, rfpwd_pkg::FRAME_W));
    c.short_one = 1'($urandom_range(0, 1));
    return c;
  endfunction

  initial begin
    decode_cfg_t c;
    logic [9:0] bit_pattern;
    sb = new();
    items_sent = 0;
    hold_cycles = 0;
    calm = 0;
    half_pending = 0;
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= rfpwd_pkg::REG_SHORT_MIN;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_pulse_len <= '0;
    in_end_of_burst <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Saturated pair never syncs, burst ends on the first half of a pair
    send_pulse(rfpwd_pkg::SAT_LEN, 1'b0);
    send_pulse(rfpwd_pkg::SAT_LEN, 1'b0);
    send_pulse(16'd0, 1'b1);
    // Sync at the range edges, ten bits at the range edges, then a broken pair
    send_pulse(rfpwd_pkg::RST_SHORT_MAX, 1'b0);
    send_pulse(rfpwd_pkg::RST_SYNC_MAX, 1'b0);
    bit_pattern = 10'b1011001110;
    for (int i = 0; i < 10; i++) begin
      send_pulse(i[0] ? rfpwd_pkg::SAT_LEN : 16'd0, 1'b0);
      if (bit_pattern[9-i])
        send_pulse(i[1] ? rfpwd_pkg::RST_SHORT_MIN : rfpwd_pkg::RST_SHORT_MAX, 1'b0);
      else
        send_pulse(i[1] ? rfpwd_pkg::RST_LONG_MIN : rfpwd_pkg::RST_LONG_MAX, 1'b0);
    end
    send_pulse(rfpwd_pkg::RST_SHORT_MIN, 1'b0);
    send_pulse(rfpwd_pkg::SAT_LEN, 1'b0);
    drain();

    // Long output hold-off while frames keep coming, then a full pause
    hold_cycles = 80;
    repeat (4) send_frame($urandom_range(10, 14), 1'b0, END_BURST);
    drain();
    run_random(200);

    c.short_min = 16'd100;   c.short_max = 16'd200;
    c.long_min  = 16'd300;   c.long_max  = 16'd400;
    c.sync_min  = 16'd1000;  c.sync_max  = 16'd2000;
    c.min_bits  = '0;        c.short_one = 1'b0;
    apply_cfg(c);
    calm = 1;
    run_random(200);
    calm = 0;

    // Overlapping short and long, sync reaching saturation, full words only
    c.short_min = 16'd500;   c.short_max = 16'd1500;
    c.long_min  = 16'd1000;  c.long_max  = 16'd2000;
    c.sync_min  = 16'd60000; c.sync_max  = 16'hFFFF;
    c.min_bits  = 6'd32;     c.short_one = 1'b1;
    apply_cfg(c);
    run_random(200);

    // Every length but saturation valid; minimum above the word size keeps frames silent
    c.short_min = 16'd0;     c.short_max = 16'hFFFF;
    c.long_min  = 16'd0;     c.long_max  = 16'hFFFF;
    c.sync_min  = 16'd0;     c.sync_max  = 16'hFFFF;
    c.min_bits  = 6'h3F;     c.short_one = 1'b0;
    apply_cfg(c);
    run_random(100);

    c.short_min = 16'd0;     c.short_max = 16'd10;
    c.long_min  = 16'd65534; c.long_max  = 16'hFFFF;
    c.sync_min  = 16'd11;    c.sync_max  = 16'd65533;
    c.min_bits  = 6'd1;      c.short_one = 1'b1;
    apply_cfg(c);
    run_random(200);

    repeat (3) begin
      apply_cfg(random_cfg());
      run_random(200);
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected frames never arrived", sb.pending()));
    if (sb.fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
design/rfpwd_pkg.sv
design/rf_pulse_width_frame_decoder.sv
dv/rf_pulse_width_frame_decoder_tb.sv
